FILE: hdl/rsch_pkg.sv
// rsch_pkg: shared types and constants for the ray/segment closest-hit block
// no dependencies; used by the divider and the top level
package rsch_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_X   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 2'd3;

  // status of the shared iterative divider
  typedef struct packed {
    logic busy;
    logic done;
  } rsch_div_stat_t;

endpackage

FILE: hdl/rsch_if.sv
// rsch_seg_if / rsch_hit_if: valid/ready channels for segments in and hits out
// no dependencies
interface rsch_seg_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_ax;
  logic signed [COORD_BITS-1:0] seg_ay;
  logic signed [COORD_BITS-1:0] seg_bx;
  logic signed [COORD_BITS-1:0] seg_by;
  logic                         last_segment;
  modport source (output valid, seg_ax, seg_ay, seg_bx, seg_by, last_segment, input ready);
  modport sink   (input valid, seg_ax, seg_ay, seg_bx, seg_by, last_segment, output ready);
endinterface

interface rsch_hit_if #(parameter int OUT_BITS = 24);
  logic                       valid;
  logic                       ready;
  logic                       any_hit;
  logic signed [OUT_BITS-1:0] near_x;
  logic signed [OUT_BITS-1:0] near_y;
  modport source (output valid, any_hit, near_x, near_y, input ready);
  modport sink   (input valid, any_hit, near_x, near_y, output ready);
endinterface

FILE: hdl/rsch_mul.sv
// rsch_mul: shared signed multiplier with a registered product
// no dependencies
module rsch_mul #(
  parameter int A_W = 25,
  parameter int B_W = 35
) (
  input  logic                     clk,
  input  logic signed [A_W-1:0]    a,
  input  logic signed [B_W-1:0]    b,
  output logic signed [A_W+B_W-1:0] prod
);

  logic signed [A_W+B_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

FILE: hdl/rsch_div.sv
// rsch_div: restoring divider, one quotient bit per cycle, msb first
// depends on rsch_pkg for the status struct
module rsch_div #(
  parameter int NUM_W = 60,
  parameter int DEN_W = 35,
  parameter int Q_W   = 25
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [NUM_W-1:0]                  num,
  input  logic [DEN_W-1:0]                  den,
  output logic [Q_W-1:0]                    quo,
  output rsch_pkg::rsch_div_stat_t          stat
);
  import rsch_pkg::*;

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] dsh_r, dsh_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = NUM_W'(den) << (Q_W - 1);
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(Q_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= dsh_r) begin
        rem_nxt = rem_r - dsh_r;
        q_nxt   = {q_r[Q_W-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[Q_W-2:0], 1'b0};
      end
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign quo       = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: hdl/ray_segment_closest_hit.sv
// ray_segment_closest_hit: nearest crossing of a configured ray with a segment stream
// a missed segment skips the divider; a crossing makes two passes through the bit-serial divider
// throughput: one segment at a time; in_seg.ready is high only while the sequencer idles
// the result of a last segment waits in an output register; the next segment is taken meanwhile
// reset: synchronous active-low rst_n clears ray registers, best hit, sequencer and output valid
module ray_segment_closest_hit #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rsch_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [COORD_BITS-1:0]               cfg_wdata,
  rsch_seg_if.sink                            in_seg,
  rsch_hit_if.source                          out_hit
);
  import rsch_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int OUT_W = C + F;
  localparam int V_W   = C + 1;
  localparam int DEN_W = 2 * C + 3;
  localparam int MA_W  = OUT_W + 1;
  localparam int MB_W  = (2 * C + 3 > OUT_W + 1) ? 2 * C + 3 : OUT_W + 1;
  localparam int P_W   = MA_W + MB_W;
  localparam int Q_W   = C + F + 1;
  localparam int DV_W  = 2 * C + 3;
  localparam int NUM_W = Q_W + DV_W;
  localparam int DIST_W = 2 * OUT_W + 4;
  localparam int SUM_W = OUT_W + 3;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_P0   = 5'd1;
  localparam logic [4:0] ST_P1   = 5'd2;
  localparam logic [4:0] ST_P2   = 5'd3;
  localparam logic [4:0] ST_P3   = 5'd4;
  localparam logic [4:0] ST_P4   = 5'd5;
  localparam logic [4:0] ST_P5   = 5'd6;
  localparam logic [4:0] ST_P6   = 5'd7;
  localparam logic [4:0] ST_TEST = 5'd8;
  localparam logic [4:0] ST_X0   = 5'd9;
  localparam logic [4:0] ST_X1   = 5'd10;
  localparam logic [4:0] ST_XW   = 5'd11;
  localparam logic [4:0] ST_Y0   = 5'd12;
  localparam logic [4:0] ST_Y1   = 5'd13;
  localparam logic [4:0] ST_YW   = 5'd14;
  localparam logic [4:0] ST_D0   = 5'd15;
  localparam logic [4:0] ST_D1   = 5'd16;
  localparam logic [4:0] ST_D2   = 5'd17;
  localparam logic [4:0] ST_FIN  = 5'd18;

  // ray registers
  logic signed [C-1:0] start_x_r, start_y_r, end_x_r, end_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      end_x_r   <= '0;
      end_y_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_START_X: start_x_r <= cfg_wdata;
        REG_START_Y: start_y_r <= cfg_wdata;
        REG_END_X:   end_x_r   <= cfg_wdata;
        REG_END_Y:   end_y_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'({1'b0, {(OUT_W-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi) sat_out = hi[OUT_W-1:0];
    else if (v < lo) sat_out = lo[OUT_W-1:0];
    else sat_out = v[OUT_W-1:0];
  endfunction

  logic [4:0]              state_r, state_nxt;
  logic                    last_r;
  logic signed [V_W-1:0]   rx_r, ry_r, sx_r, sy_r, qx_r, qy_r;
  logic signed [P_W-1:0]   acc_r;
  logic signed [DEN_W-1:0] den_r, tn_r, un_r;
  logic                    nneg_r;
  logic signed [OUT_W-1:0] px_r, py_r;
  logic                    found_r;
  logic signed [OUT_W-1:0] best_x_r, best_y_r;
  logic [DIST_W-1:0]       best_d_r;
  logic                    out_valid_r, out_any_r;
  logic signed [OUT_W-1:0] out_x_r, out_y_r;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [P_W-1:0]   prod;
  logic signed [P_W-1:0]   diff;
  logic signed [P_W-1:0]   prod_abs;
  logic                    div_start;
  logic [NUM_W-1:0]        div_num;
  logic [DV_W-1:0]         div_den;
  logic [Q_W-1:0]          quo;
  rsch_div_stat_t          div_stat;

  logic signed [OUT_W-1:0] sxs, sys, exs, eys;
  logic signed [SUM_W-1:0] qs;
  logic signed [OUT_W:0]   dx, dy;
  logic signed [DEN_W-1:0] den_n, tn_n, un_n;
  logic                    inside_hit;
  logic [DIST_W-1:0]       d2;
  logic                    in_take, out_free;

  assign sxs = OUT_W'(start_x_r) <<< F;
  assign sys = OUT_W'(start_y_r) <<< F;
  assign exs = OUT_W'(end_x_r) <<< F;
  assign eys = OUT_W'(end_y_r) <<< F;

  assign dx = (OUT_W+1)'(px_r) - (OUT_W+1)'(sxs);
  assign dy = (OUT_W+1)'(py_r) - (OUT_W+1)'(sys);

  assign diff     = acc_r - prod;
  assign prod_abs = prod[P_W-1] ? -prod : prod;

  // flip signs so the determinant is not negative
  assign den_n = den_r[DEN_W-1] ? -den_r : den_r;
  assign tn_n  = den_r[DEN_W-1] ? -tn_r  : tn_r;
  assign un_n  = den_r[DEN_W-1] ? -un_r  : un_r;
  assign inside_hit = (den_r != '0) && !tn_n[DEN_W-1] && (tn_n <= den_n)
                      && !un_n[DEN_W-1] && (un_n <= den_n);

  // rounded magnitude q from the divider, signed back and added to the start point
  assign qs = nneg_r ? -SUM_W'($signed({1'b0, quo})) : SUM_W'($signed({1'b0, quo}));

  assign d2 = DIST_W'(unsigned'(acc_r + prod));

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_P0: begin mul_a = MA_W'(rx_r); mul_b = MB_W'(sy_r); end
      ST_P1: begin mul_a = MA_W'(ry_r); mul_b = MB_W'(sx_r); end
      ST_P2: begin mul_a = MA_W'(qx_r); mul_b = MB_W'(sy_r); end
      ST_P3: begin mul_a = MA_W'(qy_r); mul_b = MB_W'(sx_r); end
      ST_P4: begin mul_a = MA_W'(qx_r); mul_b = MB_W'(ry_r); end
      ST_P5: begin mul_a = MA_W'(qy_r); mul_b = MB_W'(rx_r); end
      ST_X0: begin mul_a = MA_W'(rx_r); mul_b = MB_W'(tn_r); end
      ST_Y0: begin mul_a = MA_W'(ry_r); mul_b = MB_W'(tn_r); end
      ST_D0: begin mul_a = MA_W'(dx);   mul_b = MB_W'(dx);   end
      ST_D1: begin mul_a = MA_W'(dy);   mul_b = MB_W'(dy);   end
      default: ;
    endcase
  end

  rsch_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign div_start = (state_r == ST_X1) || (state_r == ST_Y1);
  assign div_num   = (NUM_W'(unsigned'(prod_abs)) << (F + 1)) + NUM_W'(unsigned'(den_r));
  assign div_den   = DV_W'(unsigned'(den_r)) << 1;

  rsch_div #(.NUM_W(NUM_W), .DEN_W(DV_W), .Q_W(Q_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .stat  (div_stat)
  );

  assign in_take  = in_seg.valid && in_seg.ready;
  assign out_free = !out_valid_r || out_hit.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_P0;
      ST_P0:   state_nxt = ST_P1;
      ST_P1:   state_nxt = ST_P2;
      ST_P2:   state_nxt = ST_P3;
      ST_P3:   state_nxt = ST_P4;
      ST_P4:   state_nxt = ST_P5;
      ST_P5:   state_nxt = ST_P6;
      ST_P6:   state_nxt = ST_TEST;
      ST_TEST: state_nxt = inside_hit ? ST_X0 : ST_FIN;
      ST_X0:   state_nxt = ST_X1;
      ST_X1:   state_nxt = ST_XW;
      ST_XW:   if (div_stat.done) state_nxt = ST_Y0;
      ST_Y0:   state_nxt = ST_Y1;
      ST_Y1:   state_nxt = ST_YW;
      ST_YW:   if (div_stat.done) state_nxt = ST_D0;
      ST_D0:   state_nxt = ST_D1;
      ST_D1:   state_nxt = ST_D2;
      ST_D2:   state_nxt = ST_FIN;
      ST_FIN:  if (!last_r || out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      found_r     <= 1'b0;
      best_x_r    <= '0;
      best_y_r    <= '0;
      best_d_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_D2 && (!found_r || d2 < best_d_r)) begin
        found_r  <= 1'b1;
        best_x_r <= px_r;
        best_y_r <= py_r;
        best_d_r <= d2;
      end
      if (state_r == ST_FIN && last_r && out_free) begin
        out_valid_r <= 1'b1;
        found_r     <= 1'b0;
        best_x_r    <= '0;
        best_y_r    <= '0;
        best_d_r    <= '0;
      end else if (out_valid_r && out_hit.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      last_r <= in_seg.last_segment;
      rx_r   <= V_W'(end_x_r) - V_W'(start_x_r);
      ry_r   <= V_W'(end_y_r) - V_W'(start_y_r);
      sx_r   <= V_W'(in_seg.seg_bx) - V_W'(in_seg.seg_ax);
      sy_r   <= V_W'(in_seg.seg_by) - V_W'(in_seg.seg_ay);
      qx_r   <= V_W'(in_seg.seg_ax) - V_W'(start_x_r);
      qy_r   <= V_W'(in_seg.seg_ay) - V_W'(start_y_r);
    end
    case (state_r)
      ST_P1, ST_P3, ST_P5, ST_D1: acc_r <= prod;
      ST_P2: den_r <= diff[DEN_W-1:0];
      ST_P4: tn_r  <= diff[DEN_W-1:0];
      ST_P6: un_r  <= diff[DEN_W-1:0];
      ST_TEST: begin
        den_r <= den_n;
        tn_r  <= tn_n;
      end
      ST_X1, ST_Y1: nneg_r <= prod[P_W-1];
      ST_XW: if (div_stat.done) px_r <= sat_out(SUM_W'(sxs) + qs);
      ST_YW: if (div_stat.done) py_r <= sat_out(SUM_W'(sys) + qs);
      default: ;
    endcase
    if (state_r == ST_FIN && last_r && out_free) begin
      out_any_r <= found_r;
      out_x_r   <= found_r ? best_x_r : exs;
      out_y_r   <= found_r ? best_y_r : eys;
    end
  end

  assign in_seg.ready    = (state_r == ST_IDLE);
  assign out_hit.valid   = out_valid_r;
  assign out_hit.any_hit = out_any_r;
  assign out_hit.near_x  = out_x_r;
  assign out_hit.near_y  = out_y_r;

  // the divider runs only while the sequencer waits on it
  assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_XW || state_r == ST_YW))
    else $error("divider finished outside a wait state");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_seg.ready |-> !div_stat.busy)
    else $error("segment accepted while divider busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    !found_r |-> (best_d_r == '0))
    else $error("best distance kept without a hit");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && last_r && out_free) |=> (out_valid_r && !found_r))
    else $error("result not posted or best hit not cleared");

endmodule

FILE: sim/rsch_tb_if.sv
`timescale 1ns / 1ps
// testbench-side probe interface for the ray/segment closest-hit block
// no dependencies; the segment and hit channel types themselves come from hdl/rsch_if.sv
interface rsch_tb_probe_if;
  logic stall_long;
endinterface

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// testbench for ray_segment_closest_hit: random and directed wall segments against
// a fixed-point nearest-crossing predictor; depends on rsch_pkg, rsch_if, rsch_tb_if and the block
module testbench;
  import rsch_pkg::*;

  typedef struct {
    logic signed [15:0] ax, ay, bx, by;
    logic               last;
  } seg_t;
  typedef struct {
    logic               hit;
    logic signed [23:0] x, y;
  } hit_t;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_START_X;
  logic [15:0] cfg_wdata = 0;

  rsch_seg_if #(16) seg_ch ();
  rsch_hit_if #(24) hit_ch ();
  rsch_tb_probe_if probe ();

  ray_segment_closest_hit u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .in_seg(seg_ch.sink), .out_hit(hit_ch.source)
  );

  seg_t seg_q[$];
  hit_t hit_q[$];
  longint ray_sx, ray_sy, ray_ex, ray_ey;
  logic   found;
  longint best_px, best_py, best_d2;
  int errors = 0, n_hits = 0, n_out = 0, n_seg = 0;
  int cycles = 0;
  int hold_cycles = 0;
  bit hold_req = 0;
  bit hold_done;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (2 * n + d) / (2 * d);
    return -((-2 * n + d) / (2 * d));
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // nearest-crossing predictor, updated per accepted segment
  task automatic predict_crossing(seg_t s);
    longint rx, ry, sx, sy, qx, qy, den, tn, un, px, py, dx, dy, d2;
    hit_t h;
    rx = ray_ex - ray_sx; ry = ray_ey - ray_sy;
    sx = longint'(s.bx) - s.ax; sy = longint'(s.by) - s.ay;
    qx = longint'(s.ax) - ray_sx; qy = longint'(s.ay) - ray_sy;
    den = rx * sy - ry * sx;
    tn = qx * sy - qy * sx;
    un = qx * ry - qy * rx;
    if (den != 0) begin
      if (den < 0) begin
        den = -den; tn = -tn; un = -un;
      end
      if (tn >= 0 && tn <= den && un >= 0 && un <= den) begin
        px = clamp24(ray_sx * 256 + round_div(rx * tn * 256, den));
        py = clamp24(ray_sy * 256 + round_div(ry * tn * 256, den));
        dx = px - ray_sx * 256; dy = py - ray_sy * 256;
        d2 = (dx * dx + dy * dy) & ((64'd1 << 52) - 1);
        if (!found || d2 < best_d2) begin
          found = 1; best_px = px; best_py = py; best_d2 = d2;
        end
      end
    end
    if (s.last) begin
      h.hit = found;
      h.x = found ? best_px[23:0] : 24'(clamp24(ray_ex * 256));
      h.y = found ? best_py[23:0] : 24'(clamp24(ray_ey * 256));
      hit_q.insert(hit_q.size(), h);
      found = 0; best_px = 0; best_py = 0; best_d2 = 0;
    end
  endtask

  // driver: one queued segment at a time, random idle cycles between transactions
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      seg_ch.valid <= 0;
      {seg_ch.seg_ax, seg_ch.seg_ay, seg_ch.seg_bx, seg_ch.seg_by} <= '0;
      seg_ch.last_segment <= 0;
    end else if (seg_ch.valid && seg_ch.ready) begin
      predict_crossing(seg_q.pop_front());
      n_seg++;
      seg_ch.valid <= 0;
      in_gap <= $urandom_range(0, 7);
    end else if (!seg_ch.valid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (seg_q.size() != 0) begin
        seg_ch.valid <= 1;
        seg_ch.seg_ax <= seg_q[0].ax; seg_ch.seg_ay <= seg_q[0].ay;
        seg_ch.seg_bx <= seg_q[0].bx; seg_ch.seg_by <= seg_q[0].by;
        seg_ch.last_segment <= seg_q[0].last;
      end
    end
  end

  // long hold-off on the result side, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
      hold_done <= 0;
    end else if (hold_req && !hold_done) begin
      hold_cycles <= 3000;
      hold_done <= 1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  assign probe.stall_long = (hold_cycles > 0);

  // monitor with random and long hold-off on the result side
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      hit_ch.ready <= 0;
    end else begin
      if (hit_ch.valid && hit_ch.ready) begin
        hit_t e;
        n_out++;
        if (hit_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected hit transaction %0d", n_out);
        end else begin
          e = hit_q.pop_front();
          if (e.hit !== hit_ch.any_hit || e.x !== hit_ch.near_x || e.y !== hit_ch.near_y) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp hit=%0d x=%0d y=%0d got hit=%0d x=%0d y=%0d",
                       e.hit, e.x, e.y, hit_ch.any_hit, hit_ch.near_x, hit_ch.near_y);
          end
          if (e.hit) n_hits++;
        end
      end
      if (probe.stall_long) begin
        hit_ch.ready <= 0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        hit_ch.ready <= 0;
      end else begin
        hit_ch.ready <= 1;
        if (hit_ch.valid && hit_ch.ready)
          out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic signed [15:0] v);
    @(posedge clk);
    cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_START_X: ray_sx = v;
      REG_START_Y: ray_sy = v;
      REG_END_X:   ray_ex = v;
      default:     ray_ey = v;
    endcase
  endtask

  task automatic set_ray(int sx, int sy, int ex, int ey);
    write_reg(REG_START_X, sx[15:0]);
    write_reg(REG_START_Y, sy[15:0]);
    write_reg(REG_END_X, ex[15:0]);
    write_reg(REG_END_Y, ey[15:0]);
  endtask

  task automatic add_seg(int ax, int ay, int bx, int by, bit last);
    seg_t s;
    s.ax = ax[15:0]; s.ay = ay[15:0]; s.bx = bx[15:0]; s.by = by[15:0]; s.last = last;
    seg_q.insert(seg_q.size(), s);
  endtask

  function automatic int rnd_coord(int span);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535) - 32768;
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // wait until idle, plus the divider latency for a segment still in flight
  task automatic drain();
    while (seg_q.size() != 0 || seg_ch.valid || hit_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    ray_sx = 0; ray_sy = 0; ray_ex = 0; ray_ey = 0;
    found = 0; best_px = 0; best_py = 0; best_d2 = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    // zero-length ray at reset values never hits
    add_seg(-5, -5, 5, 5, 1);
    drain();
    set_ray(0, 0, 100, 0);
    add_seg(50, -10, 50, 10, 0);   // crossing
    add_seg(30, -10, 30, 10, 0);   // nearer crossing
    add_seg(30, 10, 30, -10, 0);   // equal distance, keep earlier
    add_seg(0, 5, 100, 5, 0);      // parallel
    add_seg(7, 7, 7, 7, 0);        // degenerate segment
    add_seg(100, 0, 100, 9, 0);    // touches ray end
    add_seg(200, -10, 200, 10, 1); // beyond ray, last
    add_seg(10, 0, 20, 0, 1);      // collinear only, no hit
    add_seg(0, -3, 0, 3, 1);       // hit at ray start
    drain();
    set_ray(-32768, -32768, 32767, 32767);
    add_seg(-32768, 32767, 32767, -32768, 0);
    add_seg(32767, 32767, 32767, -32768, 1);
    add_seg(0, 1, 1, 0, 1);        // rounded crossing
    add_seg(-1, 0, 0, -1, 1);
    drain();
    set_ray(32767, -32768, -32768, 32767);
    add_seg(-32768, -32768, 32767, 32767, 1);
    add_seg(1, 2, 3, 4, 1);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      int span;
      span = (ph == 4) ? 32767 : 200;
      set_ray(rnd_coord(span), rnd_coord(span), rnd_coord(span), rnd_coord(span));
      if (ph == 2) begin
        // long hold-off on the result side while segments keep coming
        hold_req = 1;
      end
      for (int i = 0; i < 100; i++) begin
        int ax, ay;
        ax = rnd_coord(span); ay = rnd_coord(span);
        if ($urandom_range(0, 7) == 0)
          add_seg(ax, ay, ax + $urandom_range(0, 4) - 2, ay + $urandom_range(0, 4) - 2,
                  $urandom_range(0, 2) == 0);
        else
          add_seg(ax, ay, rnd_coord(span), rnd_coord(span), $urandom_range(0, 3) == 0);
      end
      add_seg(rnd_coord(span), rnd_coord(span), rnd_coord(span), rnd_coord(span), 1);
      drain();
    end
    $display("segments: %0d, hit results: %0d (%0d with a crossing)", n_seg, n_out, n_hits);
    $display("rays: axis, both diagonals at full range, five random rays, one long output stall");
    if (errors == 0 && hit_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("errors: %0d, left over: %0d", errors, hit_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
